// ===== rtl/core/osv_pkg.sv =====
// ----------------------------------------------------------------------------
// osv_pkg
// Shared types and fixed constants for the odd-only prime sieve.
// ----------------------------------------------------------------------------
package osv_pkg;

   localparam int LimitW   = 16;   // width of the limit register
   localparam int PrimeW   = 16;   // width of a returned prime
   localparam int ScanW    = 17;   // width of the scan position
   localparam int MultW    = 18;   // width of the running multiple
   localparam int SqW      = 34;   // width of a squared candidate
   localparam int WordBits = 32;   // composite bits per memory word
   localparam int BitSelW  = 5;    // bit select within a memory word

   localparam logic [LimitW-1:0] LimitReset = 16'hFFFF;
   localparam logic [ScanW-1:0]  ScanStart  = 17'd3;
   localparam logic [PrimeW-1:0] FirstPrime = 16'd2;

   typedef enum logic [8:0] {
      ST_CLEAR   = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_SERVE   = 9'b000000100,
      ST_SCAN    = 9'b000001000,
      ST_CHECK   = 9'b000010000,
      ST_SQUARE  = 9'b000100000,
      ST_MARK_RD = 9'b001000000,
      ST_MARK_WR = 9'b010000000,
      ST_DONE    = 9'b100000000
   } osv_state_type;

   typedef struct packed {
      logic start;
      logic restart;
   } osv_cmd_type;

   typedef struct packed {
      logic              idle;
      logic              done;
      logic [PrimeW-1:0] prime;
      logic              found;
   } osv_stat_type;

endpackage

// ===== rtl/core/osv_ram.sv =====
// ----------------------------------------------------------------------------
// osv_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module osv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic                                        wr_en,
   input  logic [WIDTH-1:0]                            wr_data,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ===== rtl/core/osv_seq.sv =====
// ----------------------------------------------------------------------------
// osv_seq
// Sieve sequencer: clears the composite map, scans for the next unmarked odd
// candidate and marks its odd multiples by read-modify-write of map words.
// ----------------------------------------------------------------------------
module osv_seq
   import osv_pkg::*;
#(
   parameter int MAX_LIMIT = 65535
) (
   input  logic              clock,
   input  logic              reset,
   input  osv_cmd_type       cmd,
   input  logic [LimitW-1:0] limit,
   input  logic              take,
   output osv_stat_type      stat
);

   localparam int SieveTop = (MAX_LIMIT < 65535) ? MAX_LIMIT : 65535;
   localparam int MapBits  = SieveTop / 2 + 1;
   localparam int Depth    = (MapBits + WordBits - 1) / WordBits;
   localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam logic [AddrW-1:0]  LastAddr = AddrW'(Depth - 1);
   localparam logic [LimitW-1:0] TopLim   = LimitW'(SieveTop);
   localparam logic [MultW-1:0]  TopMult  = MultW'(SieveTop);
   localparam logic [SqW-1:0]    TopSq    = SqW'(SieveTop);

   osv_state_type     state_ff, state_in;
   logic [AddrW-1:0]  clr_ff, clr_in;
   logic              two_ff, two_in;
   logic              serve_ff, serve_in;
   logic [ScanW-1:0]  scan_ff, scan_in;
   logic [ScanW-1:0]  p_ff, p_in;
   logic [SqW-1:0]    sq_ff, sq_in;
   logic [MultW-1:0]  j_ff, j_in;
   logic [PrimeW-1:0] prime_ff, prime_in;
   logic              found_ff, found_in;

   logic [LimitW-1:0]   lim;
   logic [AddrW-1:0]    mem_addr;
   logic                mem_we;
   logic [WordBits-1:0] mem_wdata;
   logic [WordBits-1:0] mem_rdata;

   assign lim = (limit > TopLim) ? TopLim : limit;

   osv_ram #(
      .WIDTH (WordBits),
      .DEPTH (Depth)
   ) u_map (
      .clock   (clock),
      .addr    (mem_addr),
      .wr_en   (mem_we),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   // Every map access is in a cycle of its own, and a marking write always
   // lands before the next read is issued, so no forwarding is needed.
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      two_in    = two_ff;
      serve_in  = serve_ff;
      scan_in   = scan_ff;
      p_in      = p_ff;
      sq_in     = sq_ff;
      j_in      = j_ff;
      prime_in  = prime_ff;
      found_in  = found_ff;
      mem_addr  = '0;
      mem_we    = 1'b0;
      mem_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_addr = clr_ff;
            mem_we   = 1'b1;
            two_in   = 1'b0;
            scan_in  = ScanStart;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == LastAddr) begin
               clr_in   = '0;
               serve_in = 1'b0;
               state_in = serve_ff ? ST_SERVE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd.start) begin
               if (cmd.restart) begin
                  serve_in = 1'b1;
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_SERVE;
               end
            end
         end
         ST_SERVE: begin
            two_in = 1'b1;
            if (!two_ff && lim >= LimitW'(2)) begin
               prime_in = FirstPrime;
               found_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff > {1'b0, lim}) begin
               prime_in = '0;
               found_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               mem_addr = AddrW'(scan_ff >> (BitSelW + 1));
               p_in     = scan_ff;
               scan_in  = scan_ff + ScanW'(2);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            sq_in = SqW'(p_ff) * SqW'(p_ff);
            if (mem_rdata[p_ff[BitSelW:1]]) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (sq_ff <= TopSq) begin
               j_in     = sq_ff[MultW-1:0];
               state_in = ST_MARK_RD;
            end else begin
               prime_in = p_ff[PrimeW-1:0];
               found_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_MARK_RD: begin
            if (j_ff > TopMult) begin
               prime_in = p_ff[PrimeW-1:0];
               found_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               mem_addr = AddrW'(j_ff >> (BitSelW + 1));
               state_in = ST_MARK_WR;
            end
         end
         ST_MARK_WR: begin
            mem_addr  = AddrW'(j_ff >> (BitSelW + 1));
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | (WordBits'(1) << j_ff[BitSelW:1]);
            j_in      = j_ff + {p_ff, 1'b0};
            state_in  = ST_MARK_RD;
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         two_ff   <= 1'b0;
         serve_ff <= 1'b0;
         scan_ff  <= ScanStart;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         two_ff   <= two_in;
         serve_ff <= serve_in;
         scan_ff  <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      sq_ff    <= sq_in;
      j_ff     <= j_in;
      prime_ff <= prime_in;
      found_ff <= found_in;
   end

   assign stat.idle  = (state_ff == ST_IDLE);
   assign stat.done  = (state_ff == ST_DONE);
   assign stat.prime = prime_ff;
   assign stat.found = found_ff;

endmodule

// ===== rtl/core/odd_only_prime_sieve.sv =====
// ----------------------------------------------------------------------------
// odd_only_prime_sieve
// Sieve of Eratosthenes over odd numbers that returns one prime per request.
// ----------------------------------------------------------------------------
// Each request word returns one response word: the next prime up to the
// limit register, or found=0 once none is left. The composite map sits in a
// single-port RAM of 32-bit words, one bit per odd number; each odd
// candidate scanned costs one read of it, and each odd multiple marked one
// read and one write, each access in a step of its own.
// After reset, and at the start of a request with restart set, the map is
// cleared one word per cycle over its ceil((min(MAX_LIMIT,65535)/2+1)/32)
// words, 1024 at the default MAX_LIMIT; req_ready is low during that pass.
// A finished word waits in the output register while the next request is
// taken.
module odd_only_prime_sieve
   import osv_pkg::*;
#(
   parameter int MAX_LIMIT = 65535
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_restart,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PrimeW-1:0] rsp_prime,
   output logic              rsp_found,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [LimitW-1:0] csr_limit
);

   logic [LimitW-1:0] limit_ff, limit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PrimeW-1:0] rsp_prime_ff, rsp_prime_in;
   logic              rsp_found_ff, rsp_found_in;

   osv_cmd_type  cmd;
   osv_stat_type stat;
   logic         take;

   assign csr_ready   = 1'b1;
   assign req_ready   = stat.idle;
   assign cmd.start   = req_valid & req_ready;
   assign cmd.restart = req_restart;
   assign take        = !rsp_valid_ff || rsp_ready;

   osv_seq #(
      .MAX_LIMIT (MAX_LIMIT)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .limit (limit_ff),
      .take  (take),
      .stat  (stat)
   );

   always_comb begin
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_found_in = rsp_found_ff;
      if (csr_valid && csr_ready) begin
         limit_in = csr_limit;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (stat.done && take) begin
         rsp_valid_in = 1'b1;
         rsp_prime_in = stat.prime;
         rsp_found_in = stat.found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LimitReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_prime_ff <= rsp_prime_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_prime = rsp_prime_ff;
   assign rsp_found = rsp_found_ff;

endmodule

// ===== rtl/core/osv_checker.sv =====
// ----------------------------------------------------------------------------
// osv_checker
// Port-level checks for the odd-only prime sieve, bound to the top level.
// ----------------------------------------------------------------------------
module osv_checker
   import osv_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_restart,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [PrimeW-1:0] rsp_prime,
   input logic              rsp_found
);

   // The map is being cleared right after reset, so no request is taken.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("request or response open right after reset");

   // A restart starts a clearing pass, which keeps the request side closed.
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_restart |=> !req_ready)
      else $error("request taken during the clearing pass");

   // A word without a prime carries zero.
   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_prime == '0)
      else $error("empty response carries a nonzero prime");

   // A prime is two or an odd number above two.
   a_prime_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_prime == FirstPrime ||
                                 (rsp_prime[0] && rsp_prime > FirstPrime))
      else $error("response prime is neither two nor odd");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prime) && $stable(rsp_found))
      else $error("stalled response word changed");

endmodule

bind odd_only_prime_sieve osv_checker u_osv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_restart (req_restart),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_prime   (rsp_prime),
   .rsp_found   (rsp_found)
);

// ===== verif/sieve_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sieve_checker
// Watches the request, response and limit channels of the odd-only sieve,
// keeps its own copy of the composite map and compares every response word
// with the prime that the copy says comes next.
// ----------------------------------------------------------------------------
module sieve_checker
   import osv_pkg::*;
#(
   parameter int MAX_LIMIT = 65535
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_restart,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [PrimeW-1:0] rsp_prime,
   input  logic              rsp_found,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [LimitW-1:0] csr_limit,
   output int                error_count,
   output int                pending,
   output int                primes_checked,
   output int                empties_checked
);

   localparam int unsigned SieveTop = (MAX_LIMIT < 65535) ? MAX_LIMIT : 65535;
   localparam int unsigned MapBits  = SieveTop / 2 + 1;

   typedef struct packed {
      logic [PrimeW-1:0] prime;
      logic              found;
   } prime_word_type;

   // Bit k stands for the odd number 2k+1.
   bit               composite_bits [0:MapBits-1];
   bit               two_out;
   logic [ScanW-1:0] next_odd;
   logic [LimitW-1:0] limit_reg;
   prime_word_type   due_words [$];
   int               errors;
   int               primes;
   int               empties;

   initial begin
      errors  = 0;
      primes  = 0;
      empties = 0;
   end

   function automatic void clear_sieve();
      for (int unsigned k = 0; k < MapBits; k++) begin
         composite_bits[k] = 1'b0;
      end
      two_out  = 1'b0;
      next_odd = ScanStart;
   endfunction

   function automatic prime_word_type next_prime(input logic restart);
      longint unsigned lim;
      longint unsigned cand;
      longint unsigned mult;
      prime_word_type  word;
      lim = (limit_reg < SieveTop) ? limit_reg : SieveTop;
      word.prime = '0;
      word.found = 1'b0;
      if (restart) begin
         clear_sieve();
      end
      if (!two_out) begin
         two_out = 1'b1;
         if (lim >= 2) begin
            word.prime = FirstPrime;
            word.found = 1'b1;
            return word;
         end
      end
      while (next_odd <= lim) begin
         cand     = next_odd;
         next_odd = next_odd + ScanW'(2);
         if (!composite_bits[cand >> 1]) begin
            // Multiples are marked to the top of the map, whatever the limit.
            for (mult = cand * cand; mult <= SieveTop; mult += 2 * cand) begin
               composite_bits[mult >> 1] = 1'b1;
            end
            word.prime = PrimeW'(cand);
            word.found = 1'b1;
            return word;
         end
      end
      return word;
   endfunction

   always @(posedge clock) begin
      prime_word_type want;
      if (reset) begin
         clear_sieve();
         limit_reg = LimitReset;
         due_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            limit_reg = csr_limit;
         end
         // A response word never belongs to a request taken at the same edge,
         // so the check comes before the new prediction is queued.
         if (rsp_valid && rsp_ready) begin
            if (due_words.size() == 0) begin
               errors++;
               $display("%0t: response word with none expected, prime %0d found %0b",
                        $time, rsp_prime, rsp_found);
            end else begin
               want = due_words.pop_front();
               if (rsp_prime !== want.prime) begin
                  errors++;
                  $display("%0t: prime mismatch, expected %0d, actual %0d",
                           $time, want.prime, rsp_prime);
               end
               if (rsp_found !== want.found) begin
                  errors++;
                  $display("%0t: found mismatch, expected %0b, actual %0b",
                           $time, want.found, rsp_found);
               end
               if (want.found) begin
                  primes++;
               end else begin
                  empties++;
               end
            end
         end
         if (req_valid && req_ready) begin
            due_words.insert(due_words.size(), next_prime(req_restart));
         end
      end
      error_count     <= errors;
      pending         <= due_words.size();
      primes_checked  <= primes;
      empties_checked <= empties;
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Request stimulus and verdict for the odd-only prime sieve.
// ----------------------------------------------------------------------------
// A directed opening walks the default limit, restart, limits 0, 1 and 2,
// exhaustion, raising and lowering the limit mid-sequence. Random phases then
// change the limit while idle and stream request words with rare restarts,
// under bursty sending and a stalling receiver. sieve_checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module testbench
   import osv_pkg::*;
;

   localparam int MaxLimit      = 65535;
   localparam int DirectedItems = 23;
   localparam int RandomItems   = 557;
   localparam int QuietLimit    = 250000;
   localparam int TailCycles    = 100;

   localparam int RX_OPEN = 0;
   localparam int RX_HALF = 1;
   localparam int RX_SLOW = 2;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   logic              req_restart = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   logic [PrimeW-1:0] rsp_prime;
   logic              rsp_found;
   logic              csr_valid   = 1'b0;
   logic              csr_ready;
   logic [LimitW-1:0] csr_limit   = '0;

   int error_count;
   int pending;
   int primes_checked;
   int empties_checked;

   int requests_sent  = 0;
   int restarts_sent  = 0;
   int limits_written = 0;
   int burst_left     = 0;
   int quiet_cycles   = 0;
   int stall_mode     = RX_OPEN;
   int stall_left     = 0;

   always #5 clock = ~clock;

   odd_only_prime_sieve #(
      .MAX_LIMIT(MaxLimit)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_restart(req_restart),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_prime  (rsp_prime),
      .rsp_found  (rsp_found),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_limit  (csr_limit)
   );

   sieve_checker #(
      .MAX_LIMIT(MaxLimit)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_prime      (rsp_prime),
      .rsp_found      (rsp_found),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_limit      (csr_limit),
      .error_count    (error_count),
      .pending        (pending),
      .primes_checked (primes_checked),
      .empties_checked(empties_checked)
   );

   // The receiver switches between always ready, half ready and mostly stalled.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(RX_OPEN, RX_SLOW);
         stall_left <= $urandom_range(16, 300);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         RX_OPEN: rsp_ready <= 1'b1;
         RX_HALF: rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QuietLimit);
      $display("%0t: timeout, no word moved for %0d cycles", $time, QuietLimit);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_request(input logic restart);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_restart <= restart;
      requests_sent++;
      if (restart) begin
         restarts_sent++;
      end
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending and wait until every expected response word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_limit(input logic [LimitW-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_limit <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limits_written++;
   endtask

   initial begin
      int                phase_len;
      logic [LimitW-1:0] value;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Default limit out of reset, then a restart in the middle of a run.
      repeat (4) send_request(1'b0);
      send_request(1'b1);
      // Limits below two never give a prime.
      write_limit('0);
      send_request(1'b1);
      send_request(1'b0);
      write_limit(LimitW'(1));
      send_request(1'b1);
      // Limit two gives only 2, then stays exhausted.
      write_limit(LimitW'(2));
      send_request(1'b1);
      repeat (2) send_request(1'b0);
      // Raising the limit after exhaustion resumes the scan.
      write_limit(LimitW'(13));
      repeat (6) send_request(1'b0);
      write_limit('1);
      repeat (3) send_request(1'b0);
      // Lowering the limit below the scan position exhausts at once.
      write_limit(LimitW'(20));
      send_request(1'b0);
      write_limit('1);
      repeat (2) send_request(1'b0);

      while (requests_sent < DirectedItems + RandomItems) begin
         drain();
         if ($urandom_range(0, 4) != 0) begin
            case ($urandom_range(0, 9))
               0:       value = LimitW'($urandom_range(0, 2));
               1, 2:    value = '1;
               3, 4:    value = LimitW'($urandom_range(3, 200));
               5, 6:    value = LimitW'($urandom_range(0, 5000));
               default: value = LimitW'($urandom());
            endcase
            write_limit(value);
         end
         // Restarts are kept rare: each one costs a full marking of the
         // small primes again.
         phase_len = $urandom_range(10, 60);
         for (int i = 0; i < phase_len && requests_sent < DirectedItems + RandomItems;
              i++) begin
            if (i == 0) begin
               send_request($urandom_range(0, 7) == 0);
            end else begin
               send_request($urandom_range(0, 99) == 0);
            end
         end
      end

      drain();
      repeat (TailCycles) @(posedge clock);
      $display("Sent %0d request words, %0d with restart, over %0d limit writes.",
               requests_sent, restarts_sent, limits_written);
      $display("Checked %0d prime words and %0d exhausted words.",
               primes_checked, empties_checked);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/osv_pkg.sv
rtl/core/osv_ram.sv
rtl/core/osv_seq.sv
rtl/core/odd_only_prime_sieve.sv
rtl/core/osv_checker.sv
verif/sieve_checker.sv
verif/testbench.sv
